// ===== design/act_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// act_pkg
// Types and constants shared by the address cache top level and its store.
// ---------------------------------------------------------------------------
package act_pkg;

    localparam int ENTRIES_DEF = 8;

    localparam logic [15:0] OP_REQUEST = 16'h0001;
    localparam logic [15:0] OP_REPLY   = 16'h0002;

    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] opcode;
        logic [31:0] target_ip;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } cmd_t;

    typedef struct packed {
        logic        send_reply;
        logic        learned;
        logic        table_full;
        logic        hit;
        logic [47:0] found_mac;
    } result_t;

    typedef struct packed {
        logic        vld;
        logic [31:0] ip;
        logic [47:0] mac;
    } rd_t;

    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [47:0] mac;
    } wr_t;

endpackage : act_pkg
`default_nettype wire

// ===== design/act_entry_store.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// act_entry_store
// Entry memories for IP and MAC with per-entry valid bits; one registered
// read port and one write port.
// ---------------------------------------------------------------------------
module act_entry_store #(
    parameter int ENTRIES = act_pkg::ENTRIES_DEF,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_idx,
    output act_pkg::rd_t          rd,
    input  wire act_pkg::wr_t     wr,
    input  wire logic [IDX_W-1:0] wr_idx
);
    import act_pkg::*;

    logic [31:0]        ip_mem  [ENTRIES];
    logic [47:0]        mac_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_vld_reg;
    logic [31:0]        rd_ip_reg;
    logic [47:0]        rd_mac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            ip_mem[wr_idx]  <= wr.ip;
            mac_mem[wr_idx] <= wr.mac;
        end
        if (rd_en)
        begin
            rd_ip_reg  <= ip_mem[rd_idx];
            rd_mac_reg <= mac_mem[rd_idx];
        end
    end

    assign rd = '{vld: rd_vld_reg, ip: rd_ip_reg, mac: rd_mac_reg};

endmodule : act_entry_store
`default_nettype wire

// ===== design/arp_cache_table_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// arp_cache_table_top
// IP-to-MAC cache: learns senders of ARP packets addressed to this station
// and answers lookups, scanning the entries one per cycle with one comparator.
// ---------------------------------------------------------------------------
// Completion: a transaction that needs no table scan (lookup of IP zero, packet
//   not for us, bad opcode, sender IP zero) strobes done in the cycle after
//   acceptance and busy stays low. A scan ends early on a match; busy is high
//   during the scan.
// Throughput: one transaction per scan, set by the single memory read port
//   and comparator. Results cannot be stalled by the receiver.
// Reset: valid bits and own_ip clear at once; no clearing pass.
module arp_cache_table_top #(
    parameter int ENTRIES = act_pkg::ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire act_pkg::cmd_t cmd,
    output logic               done,
    output act_pkg::result_t   result,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata
);
    import act_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    result_t           result_reg, result_next;
    logic              done_reg, done_next;
    logic [31:0]       own_ip_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    rd_t               rd_s;
    wr_t               wr_s;
    logic [IDX_W-1:0]  wr_idx;
    logic              addressed;
    logic              match;

    act_entry_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (rd_en),
        .rd_idx (rd_idx),
        .rd     (rd_s),
        .wr     (wr_s),
        .wr_idx (wr_idx)
    );

    assign addressed = (cmd.target_ip == own_ip_reg)
                     && ((cmd.opcode == OP_REQUEST) || (cmd.opcode == OP_REPLY));
    assign match     = rd_s.vld && (rd_s.ip == cmd_reg.ip_addr);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        issue_cnt_next  = issue_cnt_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        result_next     = result_reg;
        done_next       = 1'b0;
        rd_en           = 1'b0;
        rd_idx          = issue_cnt_reg[IDX_W-1:0];
        wr_s            = '{en: 1'b0, ip: cmd_reg.ip_addr, mac: cmd_reg.mac_addr};
        wr_idx          = free_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd;
                    issue_cnt_next  = '0;
                    free_found_next = 1'b0;
                    result_next     = '0;
                    if (cmd.func == FUNC_LOOKUP)
                    begin
                        if (cmd.ip_addr == 32'd0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (!addressed)
                    begin
                        done_next = 1'b1;
                    end
                    else if (cmd.ip_addr == 32'd0)
                    begin
                        result_next.send_reply = (cmd.opcode == OP_REQUEST);
                        done_next              = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_cnt_reg != CNT_W'(ENTRIES))
                begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_idx_next  = issue_cnt_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (match)
                    begin
                        result_next = '0;
                        if (cmd_reg.func == FUNC_LOOKUP)
                        begin
                            result_next.hit       = 1'b1;
                            result_next.found_mac = rd_s.mac;
                        end
                        else
                        begin
                            result_next.send_reply = (cmd_reg.opcode == OP_REQUEST);
                        end
                        done_next  = 1'b1;
                        pend_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (!rd_s.vld && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = pend_idx_reg;
                        end
                        if (pend_idx_reg == LAST_IDX)
                        begin
                            result_next = '0;
                            if (cmd_reg.func == FUNC_PACKET)
                            begin
                                result_next.send_reply = (cmd_reg.opcode == OP_REQUEST);
                                if (free_found_reg || !rd_s.vld)
                                begin
                                    wr_s.en             = 1'b1;
                                    wr_idx              = free_found_reg ? free_idx_reg
                                                                         : pend_idx_reg;
                                    result_next.learned = 1'b1;
                                end
                                else
                                begin
                                    result_next.table_full = 1'b1;
                                end
                            end
                            done_next  = 1'b1;
                            pend_next  = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_cnt_reg  <= '0;
            pend_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
            own_ip_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_cnt_reg  <= issue_cnt_next;
            pend_reg       <= pend_next;
            free_found_reg <= free_found_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                own_ip_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pend_idx_reg <= pend_idx_next;
        free_idx_reg <= free_idx_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_no_learn_and_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.learned && result.table_full))
        else $error("learned and table_full set together");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("scan began without an accepted transaction");

    a_hit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> $past(busy))
        else $error("hit reported without a table scan");

    a_write_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_s.en |=> (done && result.learned && !busy))
        else $error("entry write not followed by a learned result");

endmodule : arp_cache_table_top
`default_nettype wire

// ===== verif/arp_cache_table_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arp_cache_table_top_tb
// Self-checking bench for the ARP address cache. A driver feeds packet and
// lookup transactions through the start/busy handshake, with random idle
// bursts. A shadow cache computes each expected result when a transaction is
// accepted, and a monitor checks every done strobe against it. The own IP
// register is rewritten between phases (zero, all ones, random values).
// ---------------------------------------------------------------------------
module arp_cache_table_top_tb;

    import act_pkg::*;

    localparam int ENTRIES    = ENTRIES_DEF;
    localparam int POOL       = 16;
    localparam int PHASE_ITEMS = 230;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    cmd_t        cmd       = '0;
    logic        done;
    result_t     result;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;

    cmd_t        arp_cmd_q[$];
    result_t     arp_result_q[$];

    logic [31:0] own_ip_cfg = '0;
    logic [31:0] cache_ip[ENTRIES];
    logic [47:0] cache_mac[ENTRIES];
    logic [31:0] ip_pool[POOL];

    int          mismatch_count = 0;
    int          gap_left       = 0;
    bit          gaps_on        = 1'b1;

    arp_cache_table_top #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int find_entry(input logic [31:0] ip);
        if (ip == '0)
            return -1;
        for (int i = 0; i < ENTRIES; i++)
            if (cache_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic result_t resolve_arp(input cmd_t c);
        result_t r;
        int      slot;
        r = '0;
        if (c.func == FUNC_PACKET)
        begin
            if (c.target_ip == own_ip_cfg && (c.opcode == OP_REQUEST || c.opcode == OP_REPLY))
            begin
                r.send_reply = (c.opcode == OP_REQUEST);
                if (c.ip_addr != '0 && find_entry(c.ip_addr) < 0)
                begin
                    slot = -1;
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (cache_ip[i] == '0)
                            slot = i;
                    if (slot >= 0)
                    begin
                        cache_ip[slot]  = c.ip_addr;
                        cache_mac[slot] = c.mac_addr;
                        r.learned       = 1'b1;
                    end
                    else
                        r.table_full = 1'b1;
                end
            end
        end
        else
        begin
            slot = find_entry(c.ip_addr);
            if (slot >= 0)
            begin
                r.hit       = 1'b1;
                r.found_mac = cache_mac[slot];
            end
        end
        return r;
    endfunction

    function automatic cmd_t make_cmd(input logic f, input logic [15:0] op,
                                      input logic [31:0] tgt, input logic [31:0] ip,
                                      input logic [47:0] mac);
        cmd_t c;
        c.func      = f;
        c.opcode    = op;
        c.target_ip = tgt;
        c.ip_addr   = ip;
        c.mac_addr  = mac;
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t        c;
        logic [63:0] r;
        int          kind;
        r           = {$urandom, $urandom};
        c.func      = 1'($urandom_range(0, 1));
        c.opcode    = 16'($urandom);
        c.target_ip = $urandom;
        c.ip_addr   = $urandom;
        c.mac_addr  = r[47:0];
        kind        = $urandom_range(0, 99);
        if (kind < 80)
        begin
            if (c.func == FUNC_PACKET)
            begin
                c.opcode = ($urandom_range(0, 1) != 0) ? OP_REQUEST : OP_REPLY;
                if ($urandom_range(0, 9) != 0)
                    c.target_ip = own_ip_cfg;
            end
            kind = $urandom_range(0, 99);
            if (kind < 6)
                c.ip_addr = '0;
            else if (kind < 88)
                c.ip_addr = ip_pool[$urandom_range(0, POOL - 1)];
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic drain_pending();
        while (arp_cmd_q.size() != 0 || arp_result_q.size() != 0 || start)
            @(posedge clk);
        repeat (ENTRIES + 4) @(posedge clk);
    endtask

    task automatic write_own_ip(input logic [31:0] value);
        drain_pending();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        own_ip_cfg = value;
    endtask

    // driver
    always @(posedge clk)
    begin
        logic next_start;
        next_start = start;
        if (start && !busy)
            arp_result_q.push_back(resolve_arp(cmd));
        if (!start || !busy)
        begin
            next_start = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (rst_n && arp_cmd_q.size() > 0)
            begin
                if (gaps_on && $urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(1, 11) - 1;
                else
                begin
                    cmd       <= arp_cmd_q.pop_front();
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (arp_result_q.size() == 0)
                report_mismatch("done with no transaction pending", result.found_mac, '0);
            else
            begin
                want = arp_result_q.pop_front();
                if (result.send_reply !== want.send_reply)
                    report_mismatch("send_reply", 48'(result.send_reply),
                                    48'(want.send_reply));
                if (result.learned !== want.learned)
                    report_mismatch("learned", 48'(result.learned), 48'(want.learned));
                if (result.table_full !== want.table_full)
                    report_mismatch("table_full", 48'(result.table_full),
                                    48'(want.table_full));
                if (result.hit !== want.hit)
                    report_mismatch("hit", 48'(result.hit), 48'(want.hit));
                if (result.found_mac !== want.found_mac)
                    report_mismatch("found_mac", result.found_mac, want.found_mac);
            end
        end
    end

    initial
    begin
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        logic [31:0] ip_c;
        logic [31:0] ones;
        logic [31:0] v;
        ip_a = 32'hC0A8_0001;
        ip_b = 32'h0A00_0002;
        ip_c = 32'h8000_0000;
        ones = 32'hFFFF_FFFF;
        for (int i = 0; i < ENTRIES; i++)
        begin
            cache_ip[i]  = '0;
            cache_mac[i] = '0;
        end
        ip_pool[0] = ip_a;
        ip_pool[1] = ones;
        ip_pool[2] = ip_c;
        ip_pool[3] = ip_b;
        ip_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL; i++)
        begin
            do
                v = $urandom;
            while (v == '0);
            ip_pool[i] = v;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // own IP still at reset value
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, '0, '0, '0, '0));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REQUEST, '0, ip_a, 48'hFFFF_FFFF_FFFF));

        write_own_ip(ones);
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REPLY, ones, ones, '0));
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, '0, '0, ones, '0));
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, '0, '0, ip_a, '0));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REQUEST, ones, ip_a, 48'h1234_5678_9ABC));
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, '0, '0, ip_a, '0));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, 16'h0000, ones, ip_b, 48'h1));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, 16'hFFFF, ones, ip_b, 48'h2));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, 16'h0003, ones, ip_b, 48'h3));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, 16'h0100, ones, ip_b, 48'h4));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, 16'h0200, ones, ip_b, 48'h5));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REQUEST, 32'hFFFF_FFFE, ip_b, 48'h6));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REQUEST, '0, ip_b, 48'h7));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REQUEST, ones, '0, 48'h8));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REPLY, ones, '0, 48'h9));
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, '0, '0, '0, '0));
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, '0, '0, ip_b, '0));
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, 16'hFFFF, '0, ones, 48'hFFFF_FFFF_FFFF));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REPLY, ones, ip_c, 48'hA5A5_A5A5_A5A5));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REQUEST, ones, ip_b, 48'h5A5A_5A5A_5A5A));
        arp_cmd_q.push_back(make_cmd(FUNC_PACKET, OP_REPLY, ones, 32'h0000_0001, 48'h8000_0000_0001));
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, '0, '0, ip_c, '0));
        arp_cmd_q.push_back(make_cmd(FUNC_LOOKUP, '0, '0, ip_b, '0));

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:       v = '0;
                2:       v = ones;
                default: v = $urandom;
            endcase
            write_own_ip(v);
            if (phase == 4)
                gaps_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                arp_cmd_q.push_back(rand_cmd());
        end

        drain_pending();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/act_pkg.sv
design/act_entry_store.sv
design/arp_cache_table_top.sv
verif/arp_cache_table_top_tb.sv
